// ===== rtl/tdts_pkg.sv =====
package tdts_pkg;

	localparam int NUM_TASKS = 8;
	localparam int ID_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_CREATE   = 3'd1;
	localparam logic [2:0] OP_RESUME   = 3'd2;
	localparam logic [2:0] OP_PEND     = 3'd3;
	localparam logic [2:0] OP_DELAY    = 3'd4;
	localparam logic [2:0] OP_DISPATCH = 3'd5;

	localparam logic [16:0] TPS_RESET = 17'd1000;

	// x/1000 == (x>>3)/125; 1/125 as ceil(2^36/125), exact for 29-bit dividends
	localparam logic [29:0] RECIP_125 = 30'd549755814;
	localparam int          RECIP_SH  = 36;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  task_id;
		logic        enable;
		logic [31:0] delay_ms;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        found;
		logic [2:0]  dispatched_id;
		logic [31:0] tick_now;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic div;
		logic dly_wr;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       id_ok;
		logic       due;
		logic       scan_last;
	} status_t;

endpackage

// ===== rtl/tdts_ctrl.sv =====
module tdts_ctrl
	import tdts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_RESP = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.op == OP_DELAY && status.id_ok) begin
					state_d = ST_MUL;
				end else if (status.op == OP_DISPATCH) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_MUL: begin
				cmd.div = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.dly_wr = 1'b1;
				state_d    = ST_RESP;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.due || status.scan_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule

// ===== rtl/tdts_dpath.sv =====
module tdts_dpath
	import tdts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  cmd_t        cmd,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data,
	output status_t     status,
	output result_t     result
);

	logic [16:0]     tps_q;
	logic [31:0]     tick_q;
	logic [ID_W-1:0] ptr_q;
	logic            run_en_q [NUM_TASKS];
	logic [31:0]     dbegin_q [NUM_TASKS];
	logic [31:0]     dlen_q   [NUM_TASKS];

	item_t           item_q;
	logic [31:0]     prod_q;
	logic [31:0]     quot_q;

	logic [ID_W-1:0] slot_q;
	logic [ID_W-1:0] cnt_q;
	logic            acc_q;
	logic            found_q;
	logic [ID_W-1:0] did_q;

	logic [ID_W-1:0] idx;
	logic            id_ok;
	logic [48:0]     mul_full;
	logic [58:0]     div_full;
	logic [31:0]     due_sum;
	logic            due;
	logic [ID_W-1:0] slot_next;

	assign idx      = item_q.task_id[ID_W-1:0];
	assign id_ok    = {1'b0, item_q.task_id} < 9'(NUM_TASKS);
	assign mul_full = item_q.delay_ms * tps_q;
	assign div_full = prod_q[31:3] * RECIP_125;
	assign due_sum  = dbegin_q[slot_q] + dlen_q[slot_q];
	assign due      = run_en_q[slot_q] && (due_sum <= tick_q);
	assign slot_next = (slot_q == ID_W'(NUM_TASKS - 1)) ? '0 : slot_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			prod_q <= mul_full[31:0];
		end
		if (cmd.div) begin
			quot_q <= 32'(div_full[58:RECIP_SH]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RESET;
			tick_q  <= '0;
			ptr_q   <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= 1'b0;
			found_q <= 1'b0;
			did_q   <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				run_en_q[i] <= 1'b0;
				dbegin_q[i] <= '0;
				dlen_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			if (cmd.exec) begin
				found_q <= 1'b0;
				did_q   <= '0;
				slot_q  <= ptr_q;
				cnt_q   <= '0;
				acc_q   <= 1'b0;
				case (item_q.op)
					OP_TICK: begin
						tick_q <= tick_q + 32'd1;
						acc_q  <= 1'b1;
					end
					OP_CREATE: begin
						acc_q <= id_ok;
						if (id_ok) begin
							run_en_q[idx] <= item_q.enable;
							dbegin_q[idx] <= '0;
							dlen_q[idx]   <= '0;
						end
					end
					OP_RESUME, OP_PEND: begin
						acc_q <= id_ok;
						if (id_ok) begin
							run_en_q[idx] <= (item_q.op == OP_RESUME);
						end
					end
					OP_DELAY: begin
						acc_q <= id_ok;
					end
					OP_DISPATCH: begin
						acc_q <= 1'b1;
					end
					default: begin
						acc_q <= 1'b0;
					end
				endcase
			end
			if (cmd.dly_wr) begin
				dbegin_q[idx] <= tick_q;
				dlen_q[idx]   <= quot_q;
			end
			if (cmd.scan) begin
				if (due) begin
					dbegin_q[slot_q] <= '0;
					dlen_q[slot_q]   <= '0;
					found_q          <= 1'b1;
					did_q            <= slot_q;
					ptr_q            <= slot_next;
				end else begin
					slot_q <= slot_next;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign status.op        = item_q.op;
	assign status.id_ok     = id_ok;
	assign status.due       = due;
	assign status.scan_last = (cnt_q == ID_W'(NUM_TASKS - 1));

	assign result.accepted      = acc_q;
	assign result.found         = found_q;
	assign result.dispatched_id = 3'(did_q);
	assign result.tick_now      = tick_q;

endmodule

// ===== rtl/tick_delay_task_scheduler_top.sv =====
// Tick-driven task scheduler. Issue an item with start while busy is low; the
// result appears for exactly one cycle with done and cannot be held off, so
// capture it then. Tick, create, resume, pend, unused opcodes and a delay to an
// out-of-range slot pass through the execute and response states only; a delay
// to a valid slot also passes its ms-to-tick conversion through two registered
// multiplier stages (rate product, then reciprocal of 1000). Dispatch also
// scans the task table one slot per cycle from the scan pointer, until a due
// task is found or all NUM_TASKS slots have been looked at. cfg_ready is
// always high; write ticks_per_second only while busy is low.
module tick_delay_task_scheduler_top
	import tdts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tdts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tdts_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.status   (status),
		.result   (result)
	);

	// an accepted item always leaves idle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// result strobe lasts one cycle and frees the block
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done not a single-cycle strobe");

	// a found task only comes from an accepted dispatch
	a_found_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.found |-> result.accepted)
		else $error("found without accepted");

	// the tick counter moves by one, and only on a tick item
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && !$stable(result.tick_now) |->
			result.tick_now == $past(result.tick_now) + 32'd1)
		else $error("tick counter jumped");

endmodule
